// ===== design/atcf_pkg.sv =====
// ----------------------------------------------------------------------------
// atcf_pkg
// shared types, constants and helpers for the tilt complementary filter
// ----------------------------------------------------------------------------
package atcf_pkg;

  localparam int ACC_W = 64;
  localparam int MPL_W = 32;
  localparam int ATAN_W = 22;

  localparam logic [1:0] REG_LP_ALPHA = 2'd0;
  localparam logic [1:0] REG_ACCEL_WEIGHT = 2'd1;
  localparam logic [1:0] REG_SAMPLE_PERIOD = 2'd2;

  localparam logic [15:0] LP_ALPHA_RST = 16'd9830;
  localparam logic [15:0] ACCEL_WEIGHT_RST = 16'd655;
  localparam logic [15:0] SAMPLE_PERIOD_RST = 16'd6554;

  localparam logic signed [15:0] TILT_LIMIT = 16'sd23040;
  localparam logic signed [10:0] FUSED_MAX = 11'sd1023;
  localparam logic signed [10:0] FUSED_MIN = -11'sd1024;

  typedef struct packed {
    logic load;
    logic step;
  } mul_ctl_t;

  // divide by 2^s, rounding half away from zero
  function automatic logic signed [ACC_W-1:0] rshr(input logic signed [ACC_W-1:0] v,
                                                   input int unsigned s);
    logic signed [ACC_W-1:0] h;
    h = 64'sd1 <<< (s - 1);
    if (v[ACC_W-1]) begin
      return (v + h - 64'sd1) >>> s;
    end
    return (v + h) >>> s;
  endfunction

  // atan(2^-i) in degrees with 16 fraction bits
  function automatic logic [ATAN_W-1:0] atan_deg(input logic [4:0] i);
    case (i)
      5'd0: return 22'd2949120;
      5'd1: return 22'd1740967;
      5'd2: return 22'd919879;
      5'd3: return 22'd466945;
      5'd4: return 22'd234379;
      5'd5: return 22'd117304;
      5'd6: return 22'd58666;
      5'd7: return 22'd29335;
      5'd8: return 22'd14668;
      5'd9: return 22'd7334;
      5'd10: return 22'd3667;
      5'd11: return 22'd1833;
      5'd12: return 22'd917;
      5'd13: return 22'd458;
      5'd14: return 22'd229;
      5'd15: return 22'd115;
      5'd16: return 22'd57;
      5'd17: return 22'd29;
      5'd18: return 22'd14;
      5'd19: return 22'd7;
      5'd20: return 22'd4;
      5'd21: return 22'd2;
      5'd22: return 22'd1;
      default: return 22'd0;
    endcase
  endfunction

endpackage

// ===== design/atcf_serial_mul.sv =====
// ----------------------------------------------------------------------------
// atcf_serial_mul
// shift-add multiply-accumulate, one multiplier bit per cycle while step is high
// ----------------------------------------------------------------------------
module atcf_serial_mul (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  atcf_pkg::mul_ctl_t                   ctl,
  input  logic signed [atcf_pkg::ACC_W-1:0]    init,
  input  logic signed [atcf_pkg::ACC_W-1:0]    mcand,
  input  logic        [atcf_pkg::MPL_W-1:0]    mplier,
  output logic signed [atcf_pkg::ACC_W-1:0]    acc
);

  logic signed [atcf_pkg::ACC_W-1:0] acc_r;
  logic signed [atcf_pkg::ACC_W-1:0] a_r;
  logic        [atcf_pkg::MPL_W-1:0] b_r;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      acc_r <= init;
      a_r <= mcand;
      b_r <= mplier;
    end else if (ctl.step) begin
      if (b_r[0]) begin
        acc_r <= acc_r + a_r;
      end
      a_r <= a_r <<< 1;
      b_r <= b_r >> 1;
    end
  end

  assign acc = acc_r;

  a_ctl_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.load && ctl.step))
    else $error("multiplier load and step together");

  a_step_shifts: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.step && !ctl.load |=> b_r == ($past(b_r) >> 1))
    else $error("multiplier operand did not shift");

  a_load_takes: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load |=> acc_r == $past(init))
    else $error("multiplier load lost");

endmodule

// ===== design/accel_tilt_complementary_filter.sv =====
// ----------------------------------------------------------------------------
// accel_tilt_complementary_filter
// low-pass accel, sqrt + cordic tilt, gyro/accel complementary fusion
// ----------------------------------------------------------------------------
// channel  dir  transaction
// in_      in   tdata: accel_x, accel_y, accel_z, gyro_rate
// out_     out  tdata: fused_angle, accel_tilt
// cfg_     in   apb write/read of lp_alpha, accel_weight, sample_period
//
// one sample runs through the serial multiplier (low-pass, squares, gyro,
// fusion), the square root loop and the CORDIC loop before the next is taken
// in_tready is high only when idle; a result waits in the output register
// reset clears filter state, angle estimate and registers to defaults
// ----------------------------------------------------------------------------
module accel_tilt_complementary_filter #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // accel_x, accel_y, accel_z, gyro_rate
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // fused_angle, accel_tilt, zero fill
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int AW = atcf_pkg::ACC_W;
  localparam logic [4:0] LAST_COR = 5'(CORDIC_STEPS - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_LP_LD, S_LP_RUN, S_LP_WB, S_SQ_LD, S_SQ_RUN, S_SQRT,
    S_COR_LD, S_COR, S_GY_LD, S_GY_RUN, S_FU_LD, S_FU_RUN, S_DONE
  } state_t;

  state_t state_r;

  logic [15:0] lp_alpha_r, accel_weight_r, sample_period_r;
  logic signed [15:0] x_r [3];
  logic signed [15:0] gyro_r;
  logic signed [31:0] filt_r [3];
  logic signed [10:0] est_r;
  logic [1:0] k_r;
  logic [4:0] cnt_r;
  logic [AW-1:0] n_r, res_r, bit_r;
  logic signed [39:0] cx_r, cy_r;
  logic signed [31:0] z_r;
  logic signed [15:0] tilt_r;
  logic out_valid_r;
  logic signed [10:0] out_fused_r;
  logic signed [15:0] out_tilt_r;

  atcf_pkg::mul_ctl_t mctl;
  logic signed [AW-1:0] m_init, m_cand, m_acc;
  logic [atcf_pkg::MPL_W-1:0] m_pl;
  logic signed [AW-1:0] filt_k, sq_src, g_val, rnd, q_val, f_val, sub_v, t_val;
  logic signed [39:0] xs, ys;
  logic signed [15:0] tilt_c;
  logic signed [10:0] fused_c;
  logic cfg_wr, out_free;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    case (cfg_paddr[3:2])
      atcf_pkg::REG_LP_ALPHA: cfg_prdata = {16'd0, lp_alpha_r};
      atcf_pkg::REG_ACCEL_WEIGHT: cfg_prdata = {16'd0, accel_weight_r};
      atcf_pkg::REG_SAMPLE_PERIOD: cfg_prdata = {16'd0, sample_period_r};
      default: cfg_prdata = 32'd0;
    endcase
  end

  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata = {5'd0, out_tilt_r, out_fused_r};
  assign out_free = !out_valid_r || out_tready;

  assign filt_k = AW'(filt_r[k_r]);
  assign sq_src = (k_r == 2'd0) ? AW'(filt_r[0]) : AW'(filt_r[2]);
  assign g_val = (AW'(est_r) <<< 16) + atcf_pkg::rshr(m_acc, 8);
  assign q_val = atcf_pkg::rshr(m_acc, 16);
  assign rnd = atcf_pkg::rshr(q_val, 16);
  assign sub_v = AW'(res_r) + AW'(bit_r);
  assign xs = cx_r >>> cnt_r;
  assign ys = cy_r >>> cnt_r;
  assign t_val = atcf_pkg::rshr(AW'(z_r), 8);

  always_comb begin
    if (t_val > AW'(atcf_pkg::TILT_LIMIT)) begin
      tilt_c = atcf_pkg::TILT_LIMIT;
    end else if (t_val < -AW'(atcf_pkg::TILT_LIMIT)) begin
      tilt_c = -atcf_pkg::TILT_LIMIT;
    end else begin
      tilt_c = t_val[15:0];
    end
    if (res_r == '0 && filt_r[1] == '0) begin
      tilt_c = '0;
    end
  end

  always_comb begin
    f_val = rnd;
    if (f_val > AW'(atcf_pkg::FUSED_MAX)) begin
      fused_c = atcf_pkg::FUSED_MAX;
    end else if (f_val < AW'(atcf_pkg::FUSED_MIN)) begin
      fused_c = atcf_pkg::FUSED_MIN;
    end else begin
      fused_c = f_val[10:0];
    end
  end

  always_comb begin
    mctl.load = 1'b0;
    mctl.step = 1'b0;
    m_init = '0;
    m_cand = '0;
    m_pl = '0;
    case (state_r)
      S_LP_LD: begin
        mctl.load = 1'b1;
        m_init = filt_k <<< 16;
        m_cand = (AW'(x_r[k_r]) <<< 16) - filt_k;
        m_pl = {16'd0, lp_alpha_r};
      end
      S_SQ_LD: begin
        mctl.load = 1'b1;
        m_init = (k_r == 2'd0) ? '0 : m_acc;
        m_cand = sq_src[AW-1] ? -sq_src : sq_src;
        m_pl = sq_src[AW-1] ? 32'(-sq_src) : sq_src[31:0];
      end
      S_GY_LD: begin
        mctl.load = 1'b1;
        m_cand = AW'(gyro_r);
        m_pl = {16'd0, sample_period_r};
      end
      S_FU_LD: begin
        mctl.load = 1'b1;
        m_init = g_val <<< 16;
        m_cand = (AW'(tilt_r) <<< 8) - g_val;
        m_pl = {16'd0, accel_weight_r};
      end
      S_LP_RUN, S_SQ_RUN, S_GY_RUN, S_FU_RUN: mctl.step = 1'b1;
      default: mctl.step = 1'b0;
    endcase
  end

  atcf_serial_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (mctl),
    .init   (m_init),
    .mcand  (m_cand),
    .mplier (m_pl),
    .acc    (m_acc)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      lp_alpha_r <= atcf_pkg::LP_ALPHA_RST;
      accel_weight_r <= atcf_pkg::ACCEL_WEIGHT_RST;
      sample_period_r <= atcf_pkg::SAMPLE_PERIOD_RST;
      filt_r[0] <= '0;
      filt_r[1] <= '0;
      filt_r[2] <= '0;
      est_r <= '0;
      out_valid_r <= 1'b0;
      k_r <= '0;
      cnt_r <= '0;
    end else begin
      if (cfg_wr) begin
        case (cfg_paddr[3:2])
          atcf_pkg::REG_LP_ALPHA: lp_alpha_r <= cfg_pwdata[15:0];
          atcf_pkg::REG_ACCEL_WEIGHT: accel_weight_r <= cfg_pwdata[15:0];
          atcf_pkg::REG_SAMPLE_PERIOD: sample_period_r <= cfg_pwdata[15:0];
          default: ;
        endcase
      end
      if (out_valid_r && out_tready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            x_r[0] <= in_tdata[15:0];
            x_r[1] <= in_tdata[31:16];
            x_r[2] <= in_tdata[47:32];
            gyro_r <= in_tdata[63:48];
            k_r <= 2'd0;
            state_r <= S_LP_LD;
          end
        end
        S_LP_LD: begin
          cnt_r <= '0;
          state_r <= S_LP_RUN;
        end
        S_LP_RUN: begin
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd15) begin
            state_r <= S_LP_WB;
          end
        end
        S_LP_WB: begin
          filt_r[k_r] <= 32'(atcf_pkg::rshr(m_acc, 16));
          if (k_r == 2'd2) begin
            k_r <= 2'd0;
            state_r <= S_SQ_LD;
          end else begin
            k_r <= k_r + 2'd1;
            state_r <= S_LP_LD;
          end
        end
        S_SQ_LD: begin
          cnt_r <= '0;
          state_r <= S_SQ_RUN;
        end
        S_SQ_RUN: begin
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd31) begin
            if (k_r == 2'd0) begin
              k_r <= 2'd1;
              state_r <= S_SQ_LD;
            end else begin
              n_r <= m_acc;
              res_r <= '0;
              bit_r <= AW'(1) << 62;
              cnt_r <= '0;
              state_r <= S_SQRT;
            end
          end
        end
        S_SQRT: begin
          cnt_r <= cnt_r + 5'd1;
          if (n_r >= sub_v) begin
            n_r <= n_r - sub_v;
            res_r <= (res_r >> 1) + bit_r;
          end else begin
            res_r <= res_r >> 1;
          end
          bit_r <= bit_r >> 2;
          if (cnt_r == 5'd31) begin
            state_r <= S_COR_LD;
          end
        end
        S_COR_LD: begin
          cx_r <= 40'(res_r);
          cy_r <= 40'(filt_r[1]);
          z_r <= '0;
          cnt_r <= '0;
          state_r <= S_COR;
        end
        S_COR: begin
          cnt_r <= cnt_r + 5'd1;
          if (!cy_r[39]) begin
            cx_r <= cx_r + ys;
            cy_r <= cy_r - xs;
            z_r <= z_r + 32'(atcf_pkg::atan_deg(cnt_r));
          end else begin
            cx_r <= cx_r - ys;
            cy_r <= cy_r + xs;
            z_r <= z_r - 32'(atcf_pkg::atan_deg(cnt_r));
          end
          if (cnt_r == LAST_COR) begin
            state_r <= S_GY_LD;
          end
        end
        S_GY_LD: begin
          tilt_r <= tilt_c;
          cnt_r <= '0;
          state_r <= S_GY_RUN;
        end
        S_GY_RUN: begin
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd15) begin
            state_r <= S_FU_LD;
          end
        end
        S_FU_LD: begin
          cnt_r <= '0;
          state_r <= S_FU_RUN;
        end
        S_FU_RUN: begin
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd15) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_fused_r <= fused_c;
            out_tilt_r <= tilt_r;
            est_r <= fused_c;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r == S_LP_LD)
    else $error("accepted transaction did not start filtering");

  a_done_emits: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE && out_free |=> out_valid_r && state_r == S_IDLE)
    else $error("finished result not presented");

  a_est_follows: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE && out_free |=> est_r == out_fused_r)
    else $error("angle estimate differs from output");

  a_axis_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LP_WB |-> k_r != 2'd3)
    else $error("axis index out of range");

endmodule
